// File: sv/nrm_pkg.sv
// Shared types and constants for the near rectangle merge block.
// Used by the table, merge engine and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nrm_pkg;
    localparam int MAX_RECTS = 64;
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS = COORD_BITS + 1;
    localparam int IDX_BITS = $clog2(MAX_RECTS);
    localparam int CNT_BITS = $clog2(MAX_RECTS + 1);
    localparam int ENTRY_BITS = 2 * COORD_BITS + 2 * SIZE_BITS;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  tall;
        logic [SIZE_BITS-1:0]  wide;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] left;
    } box_t;

    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        box_t                wdata;
        logic [IDX_BITS-1:0] raddr;
    } tbl_req_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_RD_A,
        ST_RD_B,
        ST_TEST,
        ST_WR_A,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_NEXT_I,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT
    } state_t;

    // Nearness along one axis.
    function automatic logic axis_near(input logic [COORD_BITS-1:0] pa,
                                       input logic [SIZE_BITS-1:0] sa,
                                       input logic [COORD_BITS-1:0] pb,
                                       input logic [SIZE_BITS-1:0] sb,
                                       input logic [COORD_BITS-1:0] margin);
        logic [SIZE_BITS+1:0] lim;
        logic [COORD_BITS-1:0] gap;
        if (pb > pa)
        begin
            gap = pb - pa;
            lim = {2'b0, sa} + {{(SIZE_BITS-COORD_BITS+2){1'b0}}, margin};
        end
        else
        begin
            gap = pa - pb;
            lim = {2'b0, sb} + {{(SIZE_BITS-COORD_BITS+2){1'b0}}, margin};
        end
        return {{(SIZE_BITS-COORD_BITS+2){1'b0}}, gap} <= lim;
    endfunction

    // Bounding span along one axis, saturated to the size range.
    function automatic logic [SIZE_BITS-1:0] span(input logic [COORD_BITS-1:0] pa,
                                                  input logic [SIZE_BITS-1:0] sa,
                                                  input logic [COORD_BITS-1:0] pb,
                                                  input logic [SIZE_BITS-1:0] sb);
        logic [SIZE_BITS:0] ea;
        logic [SIZE_BITS:0] eb;
        logic [SIZE_BITS:0] hi;
        logic [COORD_BITS-1:0] lo;
        logic [SIZE_BITS:0] s;
        ea = {1'b0, sa} + {2'b0, pa};
        eb = {1'b0, sb} + {2'b0, pb};
        hi = (ea > eb) ? ea : eb;
        lo = (pa < pb) ? pa : pb;
        s = hi - {2'b0, lo};
        return s[SIZE_BITS] ? {SIZE_BITS{1'b1}} : s[SIZE_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// File: sv/nrm_table.sv
// Rectangle table: one synchronous memory, one write and one read port.
// Depends on nrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nrm_table
    import nrm_pkg::*;
(
    input  wire logic     clk,
    input  wire tbl_req_t req,
    output box_t          rdata
);
    box_t mem [MAX_RECTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule
`default_nettype wire

// File: sv/nrm_engine.sv
// Load, merge and emit sequencer around the rectangle table.
// Depends on nrm_pkg and nrm_table.
`timescale 1ns / 1ps
`default_nettype none
module nrm_engine
    import nrm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [COORD_BITS-1:0] merge_dist,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire box_t                  in_box,
    input  wire logic                  in_last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output box_t                       out_box,
    output logic                       out_last,
    output logic                       out_ovf
);
    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic [CNT_BITS-1:0] i_reg, i_next;
    logic [CNT_BITS-1:0] j_reg, j_next;
    logic [CNT_BITS-1:0] k_reg, k_next;
    logic any_reg, any_next;
    box_t acc_reg, acc_next;
    logic [MAX_RECTS-1:0] gone_reg, gone_next;
    box_t obox_reg, obox_next;
    logic olast_reg, olast_next;
    tbl_req_t req;
    box_t rdata;
    logic hit;
    box_t merged;

    nrm_table u_table (.clk(clk), .req(req), .rdata(rdata));

    always_comb
    begin
        hit = axis_near(acc_reg.left, acc_reg.wide, rdata.left, rdata.wide, merge_dist)
            && axis_near(acc_reg.top, acc_reg.tall, rdata.top, rdata.tall, merge_dist);
        merged.wide = span(acc_reg.left, acc_reg.wide, rdata.left, rdata.wide);
        merged.tall = span(acc_reg.top, acc_reg.tall, rdata.top, rdata.tall);
        merged.left = (acc_reg.left < rdata.left) ? acc_reg.left : rdata.left;
        merged.top = (acc_reg.top < rdata.top) ? acc_reg.top : rdata.top;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        any_next = any_reg;
        acc_next = acc_reg;
        gone_next = gone_reg;
        obox_next = obox_reg;
        olast_next = olast_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < CNT_BITS'(MAX_RECTS))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = ST_PASS_START;
                    end
                end
            end
            ST_PASS_START:
            begin
                i_next = '0;
                state_next = ST_NEXT_I;
            end
            ST_NEXT_I:
            begin
                if (i_reg + 1'b1 >= count_reg)
                begin
                    k_next = '0;
                    state_next = (count_reg == '0) ? ST_LOAD : ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A:
            begin
                j_next = i_reg + 1'b1;
                any_next = 1'b0;
                gone_next = '0;
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                if (j_reg == i_reg + 1'b1)
                begin
                    acc_next = rdata;
                end
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (hit)
                begin
                    acc_next = merged;
                    any_next = 1'b1;
                    gone_next[j_reg[IDX_BITS-1:0]] = 1'b1;
                end
                if (j_reg + 1'b1 < count_reg)
                begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_RD_B;
                end
                else if (any_reg || hit)
                begin
                    state_next = ST_WR_A;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = ST_NEXT_I;
                end
            end
            ST_WR_A:
            begin
                j_next = i_reg + 1'b1;
                k_next = i_reg + 1'b1;
                state_next = ST_CMP_RD;
            end
            ST_CMP_RD:
            begin
                if (j_reg >= count_reg)
                begin
                    count_next = k_reg;
                    state_next = ST_PASS_START;
                end
                else if (gone_reg[j_reg[IDX_BITS-1:0]])
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_CMP_WR;
                end
            end
            ST_CMP_WR:
            begin
                j_next = j_reg + 1'b1;
                k_next = k_reg + 1'b1;
                state_next = ST_CMP_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                obox_next = rdata;
                olast_next = (k_reg + 1'b1 == count_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (olast_reg)
                    begin
                        count_next = '0;
                        ovf_next = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        req = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                req.we = in_valid && (count_reg < CNT_BITS'(MAX_RECTS));
                req.waddr = count_reg[IDX_BITS-1:0];
                req.wdata = in_box;
            end
            ST_RD_A:
            begin
                req.raddr = i_reg[IDX_BITS-1:0];
            end
            ST_RD_B:
            begin
                req.raddr = j_reg[IDX_BITS-1:0];
            end
            ST_WR_A:
            begin
                req.we = 1'b1;
                req.waddr = i_reg[IDX_BITS-1:0];
                req.wdata = acc_reg;
            end
            ST_CMP_RD:
            begin
                req.raddr = j_reg[IDX_BITS-1:0];
            end
            ST_CMP_WR:
            begin
                req.we = 1'b1;
                req.waddr = k_reg[IDX_BITS-1:0];
                req.wdata = rdata;
            end
            ST_EMIT_RD:
            begin
                req.raddr = k_reg[IDX_BITS-1:0];
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // The read of entry i issued in ST_RD_A returns in the first ST_RD_B
    // cycle, where it is loaded into acc while the read of entry j is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        any_reg <= any_next;
        acc_reg <= acc_next;
        gone_reg <= gone_next;
        obox_reg <= obox_next;
        olast_reg <= olast_next;
    end

    assign out_box = obox_reg;
    assign out_last = olast_reg;
    assign out_ovf = ovf_reg;
endmodule
`default_nettype wire

// File: sv/near_rectangle_merge.sv
// Top level of the near rectangle merge block: ports and config register.
// Depends on nrm_pkg and nrm_engine.
//
//  Channel  Direction  Content
//  s_axis   in         rectangle x, y, width, height; tlast ends the list
//  m_axis   out        merged rectangle; tlast marks the final one
//  cfg      in         merge distance register
//
// Loading accepts one rectangle per cycle. After the last rectangle, each
// merge pass walks the table: for each candidate i it reads entry i, tests
// each later entry against it, and on any merge writes i back and compacts
// the table; emission reads each result, then holds it in ST_EMIT.
// Reset clears the count, the drop flag and the distance register.
// A stalled output holds the merge sequencer in place.
`timescale 1ns / 1ps
`default_nettype none
module near_rectangle_merge
    import nrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // rect_x, rect_y, rect_width, rect_height, zero pad
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // out_x, out_y, out_width, out_height, zero pad
    output logic             m_axis_tlast,
    output logic             m_axis_tuser   // overflow
);
    logic [COORD_BITS-1:0] dist_reg;
    box_t in_box;
    box_t out_box;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
        end
        else if (cfg_valid)
        begin
            dist_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_box = s_axis_tdata[ENTRY_BITS-1:0];
    assign m_axis_tdata = {{(56-ENTRY_BITS){1'b0}}, out_box};

    nrm_engine u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .merge_dist(dist_reg),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_box(in_box),
        .in_last(s_axis_tlast),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_box(out_box),
        .out_last(m_axis_tlast),
        .out_ovf(m_axis_tuser)
    );
endmodule
`default_nettype wire
